FILE: rtl/core/nearest_neighbor_image_scaler_assert.svh
// Assertion macros shared by the scaler RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NNIS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NNIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/nnis_pkg.sv
package nnis_pkg;

    // Field widths fixed by the item and register formats.
    localparam int DIM_W       = 13;
    localparam int PITCH_W     = 14;
    localparam int COORD_W     = 12;
    localparam int INDEX_W     = 16;
    localparam int PIXEL_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 14;

    // Divider sizing: coordinate times dimension over dimension.
    // The quotient is always below the source dimension, so it fits DIM_W bits.
    localparam int DIVIDEND_W = COORD_W + DIM_W;
    localparam int DIVISOR_W  = DIM_W;
    localparam int QUO_W      = DIM_W;

    // Row pitch times height, and row times pitch.
    localparam int PROD_W = PITCH_W + DIM_W;

    // Request type codes.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_CFG = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_PITCH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DST_WIDTH  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DST_HEIGHT = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BGRA_ORDER = 3'd5;

    // Input item.
    typedef struct packed {
        logic               req_type;
        logic [INDEX_W-1:0] load_index;
        logic [PIXEL_W-1:0] load_word;
        logic [COORD_W-1:0] dst_x;
        logic [COORD_W-1:0] dst_y;
    } req_t;

    // Result item.
    typedef struct packed {
        logic [PIXEL_W-1:0]  pixel_rgba;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    // Divider request and response.
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

    // Control sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD,
        ST_DIV_Y,
        ST_DIV_X,
        ST_ADDR,
        ST_READ,
        ST_FINISH
    } state_t;

    // A dimension is usable when it is nonzero and no larger than the limit.
    function automatic logic dim_ok(input logic [DIM_W-1:0] d, input logic [31:0] max_dim);
        return (d != '0) && (32'(d) <= max_dim);
    endfunction

    // Swap red and blue when the source word is stored as B,G,R,A.
    function automatic logic [PIXEL_W-1:0] to_rgba(input logic [PIXEL_W-1:0] w,
                                                   input logic bgra);
        return bgra ? {w[31:24], w[7:0], w[15:8], w[23:16]} : w;
    endfunction

endpackage

FILE: rtl/core/nnis_divider.sv
module nnis_divider
    import nnis_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t div_req,
    output div_rsp_t div_rsp
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] rem_next;
    logic [QUO_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] dsr_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 take;

    // One restoring step: shift in the next dividend bit and try to subtract.
    // The quotient is known to fit QUO_W bits, so the partial remainder starts
    // from the upper dividend bits and stays below the divisor.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[QUO_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        take     = (trial >= {1'b0, dsr_reg});
        rem_next = take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    // Step counter and status flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (div_req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder, quotient and divisor registers.
    always_ff @(posedge clk)
    begin
        if (div_req.start)
        begin
            rem_reg <= DIVISOR_W'(div_req.dividend[DIVIDEND_W-1:QUO_W]);
            quo_reg <= div_req.dividend[QUO_W-1:0];
            dsr_reg <= div_req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QUO_W-2:0], take};
        end
    end

    assign div_rsp.busy     = busy_reg;
    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = quo_reg;

endmodule

FILE: rtl/core/nnis_frame_mem.sv
module nnis_frame_mem
    import nnis_pkg::*;
#(
    parameter int DEPTH = 65536,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [PIXEL_W-1:0] wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr,
    output logic [PIXEL_W-1:0] rdata
);

    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/nearest_neighbor_image_scaler.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_t: load word or fetch coordinate
// rsp       out        rsp_valid / rsp_stall  rsp_t: RGBA pixel and status
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load passes through ST_LOAD and ST_FINISH before its result is registered; a fetch
// whose check fails goes from ST_CHECK to ST_FINISH. A good fetch runs two 13-step
// divisions on the shared divider, an address multiply, and one frame memory read.
// Reset clears the configuration and control state; the frame memory is not cleared.
// A new item is taken while the previous result waits; the sequencer holds in its
// last state while the output register is still occupied and stalled.
module nearest_neighbor_image_scaler
    import nnis_pkg::*;
#(
    parameter int FRAME_WORDS = 65536,
    parameter int MAX_DIM     = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  req_t                   req,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output rsp_t                   rsp,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    `include "nearest_neighbor_image_scaler_assert.svh"

    localparam int          AW        = $clog2(FRAME_WORDS);
    localparam logic [31:0] FW_LIMIT  = 32'(FRAME_WORDS);
    localparam logic [31:0] DIM_LIMIT = 32'(MAX_DIM);

    // Configuration registers.
    logic [DIM_W-1:0]   src_width_reg;
    logic [DIM_W-1:0]   src_height_reg;
    logic [PITCH_W-1:0] row_pitch_reg;
    logic [DIM_W-1:0]   dst_width_reg;
    logic [DIM_W-1:0]   dst_height_reg;
    logic               bgra_order_reg;

    // Sequencer and item state.
    state_t              state_reg;
    state_t              state_next;
    req_t                item_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [QUO_W-1:0]    sy_reg;
    logic [AW-1:0]       addr_reg;
    rsp_t                rsp_reg;
    rsp_t                rsp_next;
    logic                rsp_valid_reg;

    // Control strobes from the sequencer.
    logic                accept;
    logic                out_free;
    logic                rsp_load;
    logic                div_start;
    logic                div_sel_x;
    logic                mem_we;
    logic                mem_re;

    // Datapath.
    logic [PROD_W-1:0]   frame_size;
    logic                cfg_good;
    logic                coord_good;
    logic [STATUS_W-1:0] chk_status;
    logic [31:0]         load_idx_ext;
    logic                load_good;
    logic [PROD_W-1:0]   addr_prod;
    logic [31:0]         addr_sum;
    logic                addr_good;
    logic [PIXEL_W-1:0]  mem_rdata;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    assign cfg_ready = 1'b1;
    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= '0;
            src_height_reg <= '0;
            row_pitch_reg  <= '0;
            dst_width_reg  <= '0;
            dst_height_reg <= '0;
            bgra_order_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_SRC_HEIGHT: src_height_reg <= cfg_data[DIM_W-1:0];
                CFG_ROW_PITCH:  row_pitch_reg  <= cfg_data[PITCH_W-1:0];
                CFG_DST_WIDTH:  dst_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_DST_HEIGHT: dst_height_reg <= cfg_data[DIM_W-1:0];
                CFG_BGRA_ORDER: bgra_order_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Configuration and coordinate checks for a fetch.
    assign frame_size = PROD_W'(row_pitch_reg) * PROD_W'(src_height_reg);
    assign cfg_good   = dim_ok(src_width_reg, DIM_LIMIT) && dim_ok(src_height_reg, DIM_LIMIT)
                     && dim_ok(dst_width_reg, DIM_LIMIT) && dim_ok(dst_height_reg, DIM_LIMIT)
                     && (row_pitch_reg >= PITCH_W'(src_width_reg))
                     && (32'(frame_size) <= FW_LIMIT);
    assign coord_good = (DIM_W'(item_reg.dst_x) < dst_width_reg)
                     && (DIM_W'(item_reg.dst_y) < dst_height_reg);
    assign chk_status = !cfg_good ? STAT_BAD_CFG : (!coord_good ? STAT_RANGE : STAT_OK);

    // Load index range.
    assign load_idx_ext = 32'(item_reg.load_index);
    assign load_good    = (load_idx_ext < FW_LIMIT);

    // Source address from the two quotients; the row quotient is held in sy_reg.
    assign addr_prod = PROD_W'(sy_reg) * PROD_W'(row_pitch_reg);
    assign addr_sum  = 32'(addr_prod) + 32'(div_rsp.quotient);
    assign addr_good = (addr_sum < FW_LIMIT);

    // Divider operands: row first, then column.
    always_comb
    begin
        div_req.start = div_start;
        if (div_sel_x)
        begin
            div_req.dividend = DIVIDEND_W'(item_reg.dst_x) * DIVIDEND_W'(src_width_reg);
            div_req.divisor  = dst_width_reg;
        end
        else
        begin
            div_req.dividend = DIVIDEND_W'(item_reg.dst_y) * DIVIDEND_W'(src_height_reg);
            div_req.divisor  = dst_height_reg;
        end
    end

    // Result of the item being finished.
    always_comb
    begin
        rsp_next.status = status_reg;
        if (item_reg.req_type == REQ_FETCH && status_reg == STAT_OK)
        begin
            rsp_next.pixel_rgba = to_rgba(mem_rdata, bgra_order_reg);
        end
        else
        begin
            rsp_next.pixel_rgba = '0;
        end
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer next state and strobes.
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_sel_x  = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        rsp_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.req_type == REQ_FETCH) ? ST_CHECK : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                mem_we     = load_good;
                state_next = ST_FINISH;
            end
            ST_CHECK:
            begin
                if (chk_status == STAT_OK)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_Y;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV_Y:
            begin
                if (div_rsp.done)
                begin
                    div_start  = 1'b1;
                    div_sel_x  = 1'b1;
                    state_next = ST_DIV_X;
                end
            end
            ST_DIV_X:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                state_next = addr_good ? ST_READ : ST_FINISH;
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Item payload, status and intermediate results.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
        if (state_reg == ST_LOAD)
        begin
            status_reg <= load_good ? STAT_OK : STAT_RANGE;
        end
        if (state_reg == ST_CHECK)
        begin
            status_reg <= chk_status;
        end
        if (state_reg == ST_DIV_Y && div_rsp.done)
        begin
            sy_reg <= div_rsp.quotient;
        end
        if (state_reg == ST_ADDR)
        begin
            addr_reg <= addr_sum[AW-1:0];
            if (!addr_good)
            begin
                status_reg <= STAT_RANGE;
            end
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Shared divider.
    nnis_divider u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // Source frame memory.
    nnis_frame_mem #(
        .DEPTH (FRAME_WORDS),
        .AW    (AW)
    ) u_frame_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (load_idx_ext[AW-1:0]),
        .wdata (item_reg.load_word),
        .re    (mem_re),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    // The divider is never restarted in the middle of a division.
    `NNIS_ASSERT_NOW(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")

    // Division results only show up while the sequencer waits for them.
    `NNIS_ASSERT_NOW(a_div_done_state, div_rsp.done,
        (state_reg == ST_DIV_Y) || (state_reg == ST_DIV_X), "unexpected divider completion")

    // The frame memory is read only for a fetch that passed every check.
    `NNIS_ASSERT_NOW(a_read_ok, state_reg == ST_READ,
        (status_reg == STAT_OK) && (item_reg.req_type == REQ_FETCH), "read for a failed item")

    // A new result appears only when the sequencer finishes an item.
    `NNIS_ASSERT_NEXT(a_rsp_from_finish, (state_reg != ST_FINISH) && !rsp_valid_reg,
        !rsp_valid_reg, "result without a finished item")

endmodule
